>>> rtl/apd_pkg.sv
// Shared types and constants for the adaptive pedometer.
`timescale 1ns / 1ps
`default_nettype none
package apd_pkg;

  localparam int unsigned RUN_START = 4;
  localparam int unsigned RUN_SAT   = 250;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SQ_IN_W = 35;
  localparam int SQ_RES_W = 17;

  localparam logic [15:0] DECAY_K   = 16'd65208;
  localparam logic [15:0] BLEND_OLD = 16'd45875;
  localparam logic [15:0] BLEND_NEW = 16'd19661;
  localparam logic [31:0] SWING_TIMEOUT = 32'd400;

  typedef enum logic [2:0] {
    CFG_FLOOR    = 3'd0,
    CFG_CEILING  = 3'd1,
    CFG_WEAK     = 3'd2,
    CFG_VIOLENT  = 3'd3,
    CFG_IMIN     = 3'd4,
    CFG_IMAX     = 3'd5,
    CFG_TOL_LO   = 3'd6,
    CFG_TOL_HI   = 3'd7
  } cfg_idx_t;

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_GX   = 17'h00002,
    ST_GY   = 17'h00004,
    ST_GZ   = 17'h00008,
    ST_LX   = 17'h00010,
    ST_LY   = 17'h00020,
    ST_LZ   = 17'h00040,
    ST_SQS  = 17'h00080,
    ST_SQW  = 17'h00100,
    ST_SM   = 17'h00200,
    ST_RF   = 17'h00400,
    ST_DC   = 17'h00800,
    ST_R1   = 17'h01000,
    ST_R2   = 17'h02000,
    ST_R3   = 17'h04000,
    ST_R4   = 17'h08000,
    ST_FN   = 17'h10000
  } state_t;

endpackage
`default_nettype wire

>>> rtl/adaptive_pedometer.sv
// Adaptive peak-detecting pedometer top level: sequencer, state and configuration.
`timescale 1ns / 1ps
`default_nettype none
// One accelerometer request (three axes, timestamp, sample period) produces one
// result: a counted flag, the running step total and the raw linear magnitude.
// Work is done by a small sequencer around one shared 34x17 multiplier and an
// iterative square root that yields one root bit per cycle. From acceptance to the
// result register a request passes through the gravity tracking, the squares and
// their sum (six multiplier products), the square root, then smoothing, reference
// decay and the cadence products.
// in_stall is high while a request is in work and while a finished result still
// waits on out_stall.
// Configuration writes (cfg_index selects the register in list order) are always
// taken and must be made while the block is idle.
module adaptive_pedometer (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [15:0] in_accel_x,
  input  wire signed [15:0] in_accel_y,
  input  wire signed [15:0] in_accel_z,
  input  wire        [31:0] in_time_ms,
  input  wire        [7:0]  in_period_ms,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              out_step_counted,
  output logic       [31:0] out_step_total,
  output logic       [15:0] out_motion_magnitude,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire        [2:0]  cfg_index,
  input  wire        [15:0] cfg_data
);
  import apd_pkg::*;

  state_t state_r, state_nxt;

  // configuration
  logic [14:0] floor_r, ceil_r, weak_r, violent_r;
  logic [15:0] imin_r, imax_r;
  logic [9:0]  tol_lo_r, tol_hi_r;

  // latched request
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [31:0] now_r;
  logic [13:0] ag_r;
  logic [15:0] ad_r;

  // tracker state
  logic signed [31:0] gx_r, gy_r, gz_r;
  logic [31:0] s_r, ref_r, peak_r, spt_r, last_r, avg_r, total_r;
  logic [7:0]  run_r;
  logic        swing_r;

  // scratch
  logic [SQ_IN_W-1:0] acc_r;
  logic [15:0] devs_r;
  logic [31:0] iv_r;
  logic        ev_r;
  logic [41:0] plo_r, phi_r;
  logic [47:0] pa_r;

  // multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic [31:0] prod_sh;

  // square root
  logic sq_done;
  logic [SQ_RES_W-1:0] sq_root;

  apd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  // the z square arrives in the start cycle, so it is summed on the way in
  apd_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(state_r == ST_SQS), .din(acc_r + SQ_IN_W'(prod)),
    .done_r(sq_done), .root(sq_root)
  );

  assign prod_sh   = 32'(prod >>> 16);
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE) || out_valid;

  // wide input scaled to Q18.16 and its difference to gravity
  function automatic logic signed [MUL_A_W-1:0] gdiff(input logic signed [15:0] a,
                                                      input logic signed [31:0] g);
    logic signed [MUL_A_W-1:0] w;
    w = {{2{a[15]}}, a, 16'h0000};
    return w - MUL_A_W'(g);
  endfunction

  function automatic logic signed [MUL_B_W-1:0] lin(input logic signed [15:0] a,
                                                    input logic signed [31:0] g);
    logic signed [MUL_A_W-1:0] d;
    d = gdiff(a, g);
    return MUL_B_W'(d >>> 16);
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_GX: begin mul_a = gdiff(ax_r, gx_r); mul_b = MUL_B_W'(ag_r); end
      ST_GY: begin mul_a = gdiff(ay_r, gy_r); mul_b = MUL_B_W'(ag_r); end
      ST_GZ: begin mul_a = gdiff(az_r, gz_r); mul_b = MUL_B_W'(ag_r); end
      ST_LX: begin mul_a = MUL_A_W'(lin(ax_r, gx_r)); mul_b = lin(ax_r, gx_r); end
      ST_LY: begin mul_a = MUL_A_W'(lin(ay_r, gy_r)); mul_b = lin(ay_r, gy_r); end
      ST_LZ: begin mul_a = MUL_A_W'(lin(az_r, gz_r)); mul_b = lin(az_r, gz_r); end
      ST_SM: begin
        mul_a = $signed({2'b00, devs_r, 16'h0000}) - $signed({2'b00, s_r});
        mul_b = MUL_B_W'(ad_r);
      end
      ST_RF: begin mul_a = $signed({2'b00, ref_r}); mul_b = MUL_B_W'(DECAY_K); end
      ST_R1: begin mul_a = $signed({2'b00, avg_r}); mul_b = MUL_B_W'(tol_lo_r); end
      ST_R2: begin mul_a = $signed({2'b00, avg_r}); mul_b = MUL_B_W'(tol_hi_r); end
      ST_R3: begin mul_a = $signed({2'b00, avg_r}); mul_b = MUL_B_W'(BLEND_OLD); end
      ST_R4: begin mul_a = MUL_A_W'(iv_r[15:0]); mul_b = MUL_B_W'(BLEND_NEW); end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && !in_stall) state_nxt = ST_GX;
      ST_GX:   state_nxt = ST_GY;
      ST_GY:   state_nxt = ST_GZ;
      ST_GZ:   state_nxt = ST_LX;
      ST_LX:   state_nxt = ST_LY;
      ST_LY:   state_nxt = ST_LZ;
      ST_LZ:   state_nxt = ST_SQS;
      ST_SQS:  state_nxt = ST_SQW;
      ST_SQW:  if (sq_done) state_nxt = ST_SM;
      ST_SM:   state_nxt = ST_RF;
      ST_RF:   state_nxt = ST_DC;
      ST_DC:   state_nxt = ST_R1;
      ST_R1:   state_nxt = ST_R2;
      ST_R2:   state_nxt = ST_R3;
      ST_R3:   state_nxt = ST_R4;
      ST_R4:   state_nxt = ST_FN;
      ST_FN:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // reference, threshold and swing decisions for the DC step
  logic [31:0] ref_nxt, thr, valley, peak_nxt, spt_nxt, ceil_w;
  logic        close;
  always_comb begin
    ref_nxt = (s_r > ref_r) ? s_r : prod_sh;
    if (ref_nxt < {1'b0, floor_r, 16'h0000}) ref_nxt = {1'b0, floor_r, 16'h0000};
    ceil_w = {1'b0, ceil_r, 16'h0000};
    thr    = ref_nxt >> 1;
    if (thr > ceil_w) thr = ceil_w;
    valley = thr >> 1;
    peak_nxt = peak_r;
    spt_nxt  = spt_r;
    if (s_r > peak_r) begin
      peak_nxt = s_r;
      spt_nxt  = now_r;
    end
    close = (s_r < valley) || ((now_r - spt_nxt) > SWING_TIMEOUT);
  end

  // cadence gate for the FN step
  logic [55:0] lhs;
  logic [48:0] blend;
  logic [31:0] sat_iv;
  logic [7:0]  run_inc;
  always_comb begin
    lhs    = {iv_r, 24'h000000};
    blend  = 49'(pa_r) + {2'b00, prod[30:0], 16'h0000};
    sat_iv = (iv_r > 32'h0000FFFF) ? 32'hFFFF0000 : {iv_r[15:0], 16'h0000};
    run_inc = (run_r < 8'(RUN_SAT)) ? run_r + 8'd1 : run_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      floor_r   <= 15'd410;
      ceil_r    <= 15'd2048;
      weak_r    <= 15'd614;
      violent_r <= 15'd12288;
      imin_r    <= 16'd250;
      imax_r    <= 16'd2000;
      tol_lo_r  <= 10'd154;
      tol_hi_r  <= 10'd384;
      gx_r <= '0; gy_r <= '0; gz_r <= '0;
      s_r <= '0; ref_r <= '0; peak_r <= '0; spt_r <= '0; last_r <= '0;
      avg_r <= '0; total_r <= '0; run_r <= '0; swing_r <= 1'b0;
      ev_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FLOOR:   floor_r   <= cfg_data[14:0];
          CFG_CEILING: ceil_r    <= cfg_data[14:0];
          CFG_WEAK:    weak_r    <= cfg_data[14:0];
          CFG_VIOLENT: violent_r <= cfg_data[14:0];
          CFG_IMIN:    imin_r    <= cfg_data;
          CFG_IMAX:    imax_r    <= cfg_data;
          CFG_TOL_LO:  tol_lo_r  <= cfg_data[9:0];
          CFG_TOL_HI:  tol_hi_r  <= cfg_data[9:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: if (in_valid && !in_stall) begin
          ax_r  <= in_accel_x;
          ay_r  <= in_accel_y;
          az_r  <= in_accel_z;
          now_r <= in_time_ms;
          // coefficients scale with the period, clamped
          ag_r  <= 14'((in_period_ms > 8'd40 ? 8'd40 : in_period_ms) * 14'd131);
          ad_r  <= 16'((in_period_ms > 8'd30 ? 8'd30 : in_period_ms) * 16'd1311);
        end
        ST_GY:  gx_r <= gx_r + prod_sh;
        ST_GZ:  gy_r <= gy_r + prod_sh;
        ST_LX:  gz_r <= gz_r + prod_sh;
        ST_LY:  acc_r <= SQ_IN_W'(prod);
        ST_LZ:  acc_r <= acc_r + SQ_IN_W'(prod);
        ST_SQS: acc_r <= acc_r + SQ_IN_W'(prod);
        ST_SQW: if (sq_done) begin
          devs_r <= (sq_root > SQ_RES_W'(16'hFFFF)) ? 16'hFFFF : sq_root[15:0];
        end
        ST_RF:  s_r <= s_r + prod_sh;
        ST_DC: begin
          ref_r <= ref_nxt;
          ev_r  <= 1'b0;
          iv_r  <= spt_nxt - last_r;
          if (!swing_r) begin
            if (s_r > thr) begin
              swing_r <= 1'b1;
              peak_r  <= s_r;
              spt_r   <= now_r;
            end
          end else begin
            peak_r <= peak_nxt;
            spt_r  <= spt_nxt;
            if (close) begin
              swing_r <= 1'b0;
              if (peak_nxt > {1'b0, violent_r, 16'h0000}) begin
                // violent swing wipes the cadence pattern
                run_r <= '0;
                avg_r <= '0;
              end else if (peak_nxt >= {1'b0, weak_r, 16'h0000}) begin
                ev_r <= 1'b1;
              end
            end
          end
        end
        ST_R2: plo_r <= prod[41:0];
        ST_R3: phi_r <= prod[41:0];
        ST_R4: pa_r  <= prod[47:0];
        ST_FN: begin
          out_valid            <= 1'b1;
          out_motion_magnitude <= devs_r;
          out_step_counted     <= 1'b0;
          out_step_total       <= total_r;
          if (ev_r && iv_r >= {16'h0000, imin_r}) begin
            if (iv_r <= {16'h0000, imax_r}) begin
              if (run_r != 8'd0 && avg_r != 32'd0 &&
                  (lhs < {14'h0, plo_r} || lhs > {14'h0, phi_r})) begin
                // irregular interval restarts the run
                run_r  <= 8'd1;
                avg_r  <= sat_iv;
                last_r <= spt_r;
              end else begin
                avg_r  <= (run_r != 8'd0) ? blend[47:16] : sat_iv;
                run_r  <= run_inc;
                last_r <= spt_r;
                if (run_inc == 8'(RUN_START)) begin
                  // opening run counted at once
                  total_r          <= total_r + 32'(run_inc);
                  out_step_total   <= total_r + 32'(run_inc);
                  out_step_counted <= 1'b1;
                end else if (run_inc > 8'(RUN_START)) begin
                  total_r          <= total_r + 32'd1;
                  out_step_total   <= total_r + 32'd1;
                  out_step_counted <= 1'b1;
                end
              end
            end else begin
              run_r  <= 8'd1;
              avg_r  <= sat_iv;
              last_r <= spt_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/apd_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module apd_mul (
  input  wire                                    clk,
  input  wire  signed [apd_pkg::MUL_A_W-1:0]     a,
  input  wire  signed [apd_pkg::MUL_B_W-1:0]     b,
  output logic signed [apd_pkg::MUL_P_W-1:0]     p_r
);
  import apd_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

>>> rtl/apd_sqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module apd_sqrt (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire  [apd_pkg::SQ_IN_W-1:0]      din,
  output logic                             done_r,
  output logic [apd_pkg::SQ_RES_W-1:0]     root
);
  import apd_pkg::*;

  logic [SQ_IN_W-1:0] v_r, res_r, bit_r;
  logic [SQ_IN_W-1:0] trial;

  assign trial = res_r + bit_r;
  assign root  = res_r[SQ_RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r   <= din;
        res_r <= '0;
        bit_r <= SQ_IN_W'(64'd1 << 32);
      end else if (bit_r != '0) begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == SQ_IN_W'(1)) done_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
